// ----- src/hlfa_pkg.sv -----
// Package with shared constants, types and codes of the hole list allocator.
`timescale 1ns / 1ps
package hlfa_pkg;
    localparam int MaxHoles = 64;
    localparam int IdxW = $clog2(MaxHoles);
    localparam int CntW = $clog2(MaxHoles + 1);
    localparam logic [24:0] PoolLimit = 25'd16777216;
    localparam logic [24:0] HeaderBytes = 25'd4;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0, ACT_FREE = 2'd1, ACT_RESTART = 2'd2, ACT_NOP = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NO_FIT = 2'd1, ST_FULL = 2'd2, ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0, FIT_BEST = 2'd1, FIT_WORST = 2'd2, FIT_ALT = 2'd3
    } fit_t;

    localparam logic [1:0] CfgFit = 2'd0;
    localparam logic [1:0] CfgBase = 2'd1;
    localparam logic [1:0] CfgSize = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_WAIT, S_PICK, S_POS, S_POS_WAIT, S_MERGE,
        S_SHIFT, S_SHIFT_WAIT, S_RESULT
    } state_t;
endpackage

// ----- src/hole_list_fit_allocator.sv -----
// Top level of the hole list fit allocator.
`timescale 1ns / 1ps
// Each request walks the hole table entry by entry: allocate scans the holes and, on an
// exact fit, shifts the later entries down; free finds the position, merges and may shift
// entries; restart rewrites one hole over the pool. One request is worked at a time; every
// step goes through the registered read of the table memory.
// Synchronous active-low reset restores the control registers and one hole over the pool.
module hole_list_fit_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [23:0] s_request_size,
    input  logic [31:0] s_user_address,
    input  logic [24:0] s_header_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_block_start,
    output logic [24:0] m_length_word,
    output logic [31:0] m_granted_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import hlfa_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] fit_reg;
    logic [31:0] base_reg;
    logic [24:0] size_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0] i_reg, i_next;
    logic [CntW-1:0] pick_reg, pick_next;
    logic found_reg, found_next;
    logic [24:0] plen_reg, plen_next;
    logic [23:0] poff_reg, poff_next;
    logic [24:0] prev_end_reg, prev_end_next;
    logic [24:0] need_reg, need_next;
    logic [24:0] off_reg, off_next;
    logic is_free_reg, is_free_next;
    logic [1:0] st_reg, st_next;
    logic [31:0] bs_reg, bs_next;
    logic [24:0] lw_reg, lw_next;
    logic shift_dir_reg, shift_dir_next;
    logic [CntW-1:0] stop_reg, stop_next;
    logic wr_en;
    logic [IdxW-1:0] wr_addr, rd_addr;
    logic [23:0] wr_offset, rd_offset;
    logic [24:0] wr_length, rd_length;
    logic [24:0] pool_n;
    logic [31:0] start_w, off_w;
    logic [32:0] end_w;
    logic left, right;
    logic init_reg;

    hlfa_table u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_offset(wr_offset),
        .wr_length(wr_length), .rd_addr(rd_addr), .rd_offset(rd_offset),
        .rd_length(rd_length)
    );

    assign pool_n = (size_reg > PoolLimit) ? PoolLimit : size_reg;
    assign start_w = s_user_address - 32'd4;
    assign off_w = start_w - base_reg;
    assign end_w = {1'b0, off_w} + {8'd0, s_header_length};
    assign s_ready = (state_reg == S_IDLE) && !init_reg;
    assign m_valid = (state_reg == S_RESULT);
    assign cfg_ready = 1'b1;
    assign m_status = st_reg;
    assign m_block_start = bs_reg;
    assign m_length_word = lw_reg;
    assign m_granted_address = (lw_reg != '0) ? bs_reg + 32'd4 : '0;
    assign left = (i_reg != '0) && (prev_end_reg == off_reg);
    assign right = (i_reg < cnt_reg) && (off_reg + lw_reg == {1'b0, rd_offset});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fit_reg <= FIT_FIRST;
            base_reg <= '0;
            size_reg <= 25'd65536;
            cnt_reg <= CntW'(1);
            found_reg <= 1'b0;
            is_free_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            found_reg <= found_next;
            is_free_reg <= is_free_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CfgFit:  fit_reg <= cfg_data[1:0];
                    CfgBase: base_reg <= cfg_data;
                    CfgSize: size_reg <= cfg_data[24:0];
                    default: ;
                endcase
            end
        end
        i_reg <= i_next;
        pick_reg <= pick_next;
        plen_reg <= plen_next;
        poff_reg <= poff_next;
        prev_end_reg <= prev_end_next;
        need_reg <= need_next;
        off_reg <= off_next;
        st_reg <= st_next;
        bs_reg <= bs_next;
        lw_reg <= lw_next;
        shift_dir_reg <= shift_dir_next;
        stop_reg <= stop_next;
    end

    // The table after reset holds one pool hole, written while init_reg is set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= 1'b1;
        end else begin
            init_reg <= 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        pick_next = pick_reg;
        found_next = found_reg;
        plen_next = plen_reg;
        poff_next = poff_reg;
        prev_end_next = prev_end_reg;
        need_next = need_reg;
        off_next = off_reg;
        is_free_next = is_free_reg;
        st_next = st_reg;
        bs_next = bs_reg;
        lw_next = lw_reg;
        shift_dir_next = shift_dir_reg;
        stop_next = stop_reg;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_offset = '0;
        wr_length = '0;
        rd_addr = i_reg[IdxW-1:0];
        if (init_reg) begin
            wr_en = 1'b1;
            wr_length = 25'd65536;
            cnt_next = CntW'(1);
        end
        unique case (state_reg)
            S_IDLE: begin
                i_next = '0;
                found_next = 1'b0;
                st_next = ST_OK;
                bs_next = '0;
                lw_next = '0;
                if (s_valid && !init_reg) begin
                    unique case (s_action)
                        ACT_ALLOC: begin
                            need_next = {1'b0, s_request_size} + HeaderBytes;
                            is_free_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        ACT_FREE: begin
                            is_free_next = 1'b1;
                            off_next = off_w[24:0];
                            lw_next = s_header_length;
                            if (end_w > {8'd0, pool_n}) begin
                                st_next = ST_RANGE;
                                lw_next = '0;
                                state_next = S_RESULT;
                            end else if (s_header_length == '0) begin
                                state_next = S_RESULT;
                            end else begin
                                state_next = S_POS;
                            end
                        end
                        ACT_RESTART: begin
                            wr_en = 1'b1;
                            wr_addr = '0;
                            wr_offset = '0;
                            wr_length = pool_n;
                            cnt_next = (pool_n != '0) ? CntW'(1) : '0;
                            state_next = S_RESULT;
                        end
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_reg < cnt_reg) begin
                    state_next = S_SCAN_WAIT;
                end else begin
                    state_next = S_PICK;
                end
            end
            S_SCAN_WAIT: begin
                state_next = S_SCAN;
                i_next = i_reg + CntW'(1);
                if (rd_length >= need_reg) begin
                    if (fit_reg == FIT_BEST) begin
                        if (!found_reg || rd_length < plen_reg) begin
                            pick_next = i_reg;
                            plen_next = rd_length;
                            poff_next = rd_offset;
                            found_next = 1'b1;
                        end
                    end else if (fit_reg == FIT_WORST) begin
                        if (!found_reg || rd_length > plen_reg) begin
                            pick_next = i_reg;
                            plen_next = rd_length;
                            poff_next = rd_offset;
                            found_next = 1'b1;
                        end
                    end else begin
                        pick_next = i_reg;
                        plen_next = rd_length;
                        poff_next = rd_offset;
                        found_next = 1'b1;
                        state_next = S_PICK;
                    end
                end
            end
            S_PICK: begin
                if (!found_reg) begin
                    st_next = ST_NO_FIT;
                    state_next = S_RESULT;
                end else begin
                    bs_next = base_reg + {8'd0, poff_reg};
                    lw_next = need_reg;
                    state_next = S_RESULT;
                    if (plen_reg == need_reg) begin
                        i_next = pick_reg;
                        stop_next = cnt_reg - CntW'(1);
                        cnt_next = cnt_reg - CntW'(1);
                        shift_dir_next = 1'b0;
                        state_next = S_SHIFT;
                    end else begin
                        wr_en = 1'b1;
                        wr_addr = pick_reg[IdxW-1:0];
                        wr_offset = poff_reg + need_reg[23:0];
                        wr_length = plen_reg - need_reg;
                    end
                end
            end
            S_POS: begin
                if (i_reg < cnt_reg) begin
                    state_next = S_POS_WAIT;
                end else begin
                    state_next = S_MERGE;
                end
            end
            S_POS_WAIT: begin
                if ({1'b0, rd_offset} >= off_reg) begin
                    state_next = S_MERGE;
                end else begin
                    prev_end_next = {1'b0, rd_offset} + rd_length;
                    i_next = i_reg + CntW'(1);
                    state_next = S_POS;
                end
            end
            S_MERGE: begin
                state_next = S_RESULT;
                if (left && right) begin
                    wr_en = 1'b1;
                    wr_addr = IdxW'(i_reg - CntW'(1));
                    wr_offset = 24'(prev_end_reg - plen_reg);
                    wr_length = prev_end_reg - (prev_end_reg - plen_reg)
                                + lw_reg + rd_length;
                    stop_next = cnt_reg - CntW'(1);
                    cnt_next = cnt_reg - CntW'(1);
                    shift_dir_next = 1'b0;
                    state_next = S_SHIFT;
                end else if (left) begin
                    wr_en = 1'b1;
                    wr_addr = IdxW'(i_reg - CntW'(1));
                    wr_offset = 24'(prev_end_reg - plen_reg);
                    wr_length = plen_reg + lw_reg;
                end else if (right) begin
                    wr_en = 1'b1;
                    wr_addr = i_reg[IdxW-1:0];
                    wr_offset = off_reg[23:0];
                    wr_length = rd_length + lw_reg;
                end else if (cnt_reg >= CntW'(MaxHoles)) begin
                    st_next = ST_FULL;
                end else begin
                    stop_next = i_reg;
                    i_next = cnt_reg;
                    cnt_next = cnt_reg + CntW'(1);
                    shift_dir_next = 1'b1;
                    state_next = S_SHIFT;
                end
                lw_next = '0;
                plen_next = lw_reg;
            end
            S_SHIFT: begin
                if (i_reg == stop_reg) begin
                    state_next = S_RESULT;
                    if (shift_dir_reg) begin
                        wr_en = 1'b1;
                        wr_addr = i_reg[IdxW-1:0];
                        wr_offset = off_reg[23:0];
                        wr_length = plen_reg;
                    end
                end else begin
                    rd_addr = shift_dir_reg ? IdxW'(i_reg - CntW'(1))
                                            : IdxW'(i_reg + CntW'(1));
                    state_next = S_SHIFT_WAIT;
                end
            end
            S_SHIFT_WAIT: begin
                wr_en = 1'b1;
                wr_addr = i_reg[IdxW-1:0];
                wr_offset = rd_offset;
                wr_length = rd_length;
                i_next = shift_dir_reg ? i_reg - CntW'(1) : i_reg + CntW'(1);
                state_next = S_SHIFT;
            end
            S_RESULT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_POS_WAIT && {1'b0, rd_offset} < off_reg) begin
            plen_next = rd_length;
        end
    end
endmodule

// ----- src/hlfa_table.sv -----
// Hole table memory with one write port and one registered read port.
`timescale 1ns / 1ps
module hlfa_table (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [hlfa_pkg::IdxW-1:0]   wr_addr,
    input  logic [23:0]                 wr_offset,
    input  logic [24:0]                 wr_length,
    input  logic [hlfa_pkg::IdxW-1:0]   rd_addr,
    output logic [23:0]                 rd_offset,
    output logic [24:0]                 rd_length
);
    import hlfa_pkg::*;

    logic [48:0] mem [MaxHoles];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_offset, wr_length};
        end
        {rd_offset, rd_length} <= mem[rd_addr];
    end
endmodule

// ----- src/hlfa_checker.sv -----
// Port checker for the hole list fit allocator, bound to the top level.
`timescale 1ns / 1ps
module hlfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_block_start,
    input logic [24:0] m_length_word,
    input logic [31:0] m_granted_address
);
    import hlfa_pkg::*;

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("request taken while busy");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready)) else $error("result and ready together");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped");
    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_length_word != '0) |-> m_granted_address == m_block_start + 32'd4)
        else $error("granted address mismatch");
endmodule

bind hole_list_fit_allocator hlfa_checker u_hlfa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_block_start(m_block_start), .m_length_word(m_length_word),
    .m_granted_address(m_granted_address)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the hole list fit allocator with directed and random traffic.
`timescale 1ns / 1ps
module tb_top;
    import hlfa_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] block_start;
        logic [24:0] length_word;
        logic [31:0] granted_address;
    } grant_t;

    class alloc_scoreboard;
        logic [1:0]  mode;
        logic [31:0] base;
        logic [24:0] size;
        logic [24:0] offs[MaxHoles];
        logic [24:0] lens[MaxHoles];
        int          holes;
        grant_t      pending[$];
        int          errors;

        function new();
            mode = FIT_FIRST;
            base = 0;
            size = 25'd65536;
            errors = 0;
            rebuild();
        endfunction

        function void rebuild();
            logic [24:0] n;
            n = (size > PoolLimit) ? PoolLimit : size;
            holes = 0;
            if (n != 0) begin
                offs[0] = 0;
                lens[0] = n;
                holes = 1;
            end
        endfunction

        function void drop(int i);
            for (int k = i; k + 1 < holes; k++) begin
                offs[k] = offs[k + 1];
                lens[k] = lens[k + 1];
            end
            holes--;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CfgFit) mode = val[1:0];
            else if (idx == CfgBase) base = val;
            else if (idx == CfgSize) size = val[24:0];
        endfunction

        function grant_t carve(logic [23:0] req);
            grant_t g;
            logic [24:0] need;
            int pick;
            bit found;
            logic [24:0] off;
            g = '{ST_OK, 0, 0, 0};
            need = {1'b0, req} + HeaderBytes;
            pick = 0;
            found = 0;
            for (int i = 0; i < holes; i++) begin
                if (lens[i] < need) continue;
                if (mode == FIT_BEST) begin
                    if (!found || lens[i] < lens[pick]) begin pick = i; found = 1; end
                end else if (mode == FIT_WORST) begin
                    if (!found || lens[i] > lens[pick]) begin pick = i; found = 1; end
                end else begin
                    pick = i;
                    found = 1;
                    break;
                end
            end
            if (!found) begin
                g.status = ST_NO_FIT;
                return g;
            end
            off = offs[pick];
            if (lens[pick] == need) drop(pick);
            else begin
                offs[pick] = off + need;
                lens[pick] = lens[pick] - need;
            end
            g.block_start = base + {7'd0, off};
            g.length_word = need;
            g.granted_address = g.block_start + 32'd4;
            return g;
        endfunction

        function logic [1:0] give_back(logic [31:0] ua, logic [24:0] len);
            logic [31:0] off;
            logic [24:0] n;
            int pos;
            bit l, r;
            off = ua - 32'd4 - base;
            n = (size > PoolLimit) ? PoolLimit : size;
            if ({1'b0, off} + {8'd0, len} > {8'd0, n}) return ST_RANGE;
            if (len == 0) return ST_OK;
            for (pos = 0; pos < holes; pos++)
                if ({7'd0, offs[pos]} >= off) break;
            l = pos > 0 && ({7'd0, offs[pos - 1]} + lens[pos - 1] == off);
            r = pos < holes && (off + len == {7'd0, offs[pos]});
            if (l && r) begin
                lens[pos - 1] = lens[pos - 1] + len + lens[pos];
                drop(pos);
            end else if (l) begin
                lens[pos - 1] = lens[pos - 1] + len;
            end else if (r) begin
                offs[pos] = off[24:0];
                lens[pos] = lens[pos] + len;
            end else begin
                if (holes >= MaxHoles) return ST_FULL;
                for (int k = holes; k > pos; k--) begin
                    offs[k] = offs[k - 1];
                    lens[k] = lens[k - 1];
                end
                offs[pos] = off[24:0];
                lens[pos] = len;
                holes++;
            end
            return ST_OK;
        endfunction

        function void note_request(logic [1:0] act, logic [23:0] req,
                                   logic [31:0] ua, logic [24:0] len);
            grant_t g;
            g = '{ST_OK, 0, 0, 0};
            if (act == ACT_ALLOC) g = carve(req);
            else if (act == ACT_FREE) g.status = give_back(ua, len);
            else if (act == ACT_RESTART) rebuild();
            pending.push_back(g);
        endfunction

        function void check_grant(grant_t got);
            grant_t e;
            if (pending.size() == 0) begin
                $error("unexpected result, status %0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
            if (got.block_start !== e.block_start) begin
                $error("block_start: expected %h, actual %h", e.block_start, got.block_start);
                errors++;
            end
            if (got.length_word !== e.length_word) begin
                $error("length_word: expected %h, actual %h", e.length_word, got.length_word);
                errors++;
            end
            if (got.granted_address !== e.granted_address) begin
                $error("granted_address: expected %h, actual %h",
                       e.granted_address, got.granted_address);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_action = 0;
    logic [23:0] s_request_size = 0;
    logic [31:0] s_user_address = 0;
    logic [24:0] s_header_length = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [31:0] m_block_start;
    logic [24:0] m_length_word;
    logic [31:0] m_granted_address;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;

    alloc_scoreboard board = new();
    int  cycles = 0;
    bit  hold_off = 0;
    logic [31:0] live_addr[$];
    logic [24:0] live_len[$];

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    hole_list_fit_allocator DUT (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("** hole_list_fit_allocator: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_grant('{m_status, m_block_start, m_length_word, m_granted_address});
    end

    // Receiver stall pattern, with a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 0;
        else if (cycles % 300 < 150) m_ready <= 1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send(logic [1:0] act, logic [23:0] req, logic [31:0] ua, logic [24:0] len);
        s_valid <= 1;
        s_action <= act;
        s_request_size <= req;
        s_user_address <= ua;
        s_header_length <= len;
        do @(posedge aclk); while (!s_ready);
        board.note_request(act, req, ua, len);
        if (act == ACT_ALLOC && board.pending[$].status == ST_OK) begin
            live_addr.push_back(board.pending[$].granted_address);
            live_len.push_back(board.pending[$].length_word);
        end else if (act == ACT_RESTART) begin
            live_addr.delete();
            live_len.delete();
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic random_request(logic [31:0] base);
        int r, k;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            if ($urandom_range(0, 9) == 0)
                send(ACT_ALLOC, 24'($urandom), $urandom, 25'($urandom));
            else
                send(ACT_ALLOC, 24'($urandom_range(0, 600)), $urandom, 25'($urandom));
        end else if (r < 85 && live_addr.size() > 0) begin
            k = $urandom_range(0, live_addr.size() - 1);
            send(ACT_FREE, 24'($urandom), live_addr[k], live_len[k]);
            live_addr.delete(k);
            live_len.delete(k);
        end else if (r < 93) begin
            send(ACT_FREE, 24'($urandom), base + $urandom_range(0, 70000),
                 25'($urandom_range(0, 300)));
        end else if (r < 97) begin
            send(ACT_FREE, 24'($urandom), $urandom, 25'($urandom));
        end else if (r < 99) begin
            send(ACT_NOP, 24'($urandom), $urandom, 25'($urandom));
        end else begin
            send(ACT_RESTART, 24'($urandom), $urandom, 25'($urandom));
        end
    endtask

    task automatic random_phase(int count, logic [31:0] base);
        int done;
        done = 0;
        while (done < count) begin
            for (int b = $urandom_range(1, 20); b > 0 && done < count; b--) begin
                random_request(base);
                done++;
            end
            if ($urandom_range(0, 2) == 0) begin
                s_valid <= 0;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    endtask

    initial begin
        logic [31:0] bases[4];
        logic [24:0] sizes[4];
        bases = '{32'h0, 32'hFFFF_FF00, 32'h1234_0000, 32'h8000_0000};
        sizes = '{25'd65536, 25'd1200, 25'h1FF_FFFF, 25'd16777216};
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, every action, special cases.
        send(ACT_ALLOC, 24'd0, 0, 0);
        send(ACT_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF, 25'h1FF_FFFF);
        send(ACT_ALLOC, 24'd65532, 0, 0);
        send(ACT_ALLOC, 24'd100, 0, 0);
        send(ACT_FREE, 0, 32'd4, 25'd4);
        send(ACT_FREE, 0, 32'd100, 25'd0);
        send(ACT_FREE, 0, 32'd65000, 25'd1000);
        send(ACT_FREE, 0, 32'd0, 25'd8);
        send(ACT_FREE, 0, 32'hFFFF_FFFF, 25'h1FF_FFFF);
        send(ACT_NOP, 24'hFF_FFFF, 32'hFFFF_FFFF, 25'h1FF_FFFF);
        send(ACT_RESTART, 0, 0, 0);
        for (int i = 0; i < 66; i++) send(ACT_ALLOC, 24'd4, 0, 0);
        for (int i = 0; i < 66; i += 2) send(ACT_FREE, 0, 32'd4 + 8 * i, 25'd8);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CfgFit, ph % 4);
            write_reg(CfgBase, bases[ph % 4]);
            write_reg(CfgSize, 32'(sizes[ph % 4]));
            send(ACT_RESTART, 0, 0, 0);
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge aclk);
                        hold_off = 0;
                    end
                    random_phase(60, bases[ph % 4]);
                join
            end
            random_phase(180, bases[ph % 4]);
            drain();
        end
        write_reg(CfgSize, 32'd0);
        send(ACT_RESTART, 0, 0, 0);
        send(ACT_ALLOC, 24'd0, 0, 0);
        send(ACT_FREE, 0, 32'd4, 25'd0);
        send(ACT_FREE, 0, 32'd4, 25'd1);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("** hole_list_fit_allocator: PASSED **");
        else
            $display("** hole_list_fit_allocator: FAILED **");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/hlfa_pkg.sv
src/hlfa_table.sv
src/hole_list_fit_allocator.sv
src/hlfa_checker.sv
tb/tb_top.sv
